// ===== design/rbit_pkg.sv =====
// Shared types, widths and codes for the region buffer index table.
// Used by the channel interfaces, the divider, the datapath, the controller
// and the top level. Depends on nothing.
`default_nettype none

package rbit_pkg;

  // Field widths
  localparam int unsigned CmdW        = 1;
  localparam int unsigned AddrW       = 64;
  localparam int unsigned MbW         = 16;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned BufIdxW     = 27;
  localparam int unsigned BlocksW     = 24;
  localparam int unsigned PagesW      = 11;
  localparam int unsigned MaxRegionsW = 4;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 11;

  // One MiB is 256 pages of 4096 bytes.
  localparam int unsigned PageShift   = 12;
  localparam int unsigned MibShift    = 8;

  // Divider dividend: a lookup offset in pages is below 2^35.
  localparam int unsigned DivW        = 35;
  localparam int unsigned ProdW       = BlocksW + PagesW;
  // Region end address, one bit wider than an address so it never wraps.
  localparam int unsigned LimitW      = AddrW + 1;

  // Default table depth and configuration reset values.
  localparam int unsigned MaxRegionSlots    = 8;
  localparam int unsigned BlockPagesReset   = 2;
  localparam int unsigned MaxRegionsReset   = 8;

  // Command codes
  typedef enum logic [CmdW-1:0] {
    CMD_ADD    = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLOCK_PAGES = 1'b0,
    CFG_MAX_REGIONS = 1'b1
  } cfg_idx_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_SMALL = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  // Which result the datapath should stage
  typedef enum logic [2:0] {
    RES_NONE   = 3'd0,
    RES_FULL   = 3'd1,
    RES_SMALL  = 3'd2,
    RES_MISS   = 3'd3,
    RES_ADD_OK = 3'd4,
    RES_LK_OK  = 3'd5
  } res_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic div_start;
    logic mul;
    logic write_entry;
    logic scan_clr;
    logic scan_rd;
    logic load_out;
    res_e res;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_lookup;
    logic addr_zero;
    logic full;
    logic pages_zero;
    logic div_done;
    logic quot_zero;
    logic scan_end;
    logic hit;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/rbit_chan_if.sv =====
// Valid/ready channel interfaces for the request and response words.
// Depends on rbit_pkg for the field widths.
`default_nettype none

interface rbit_req_if;
  logic                          valid;
  logic                          ready;
  logic [rbit_pkg::CmdW-1:0]     cmd;
  logic [rbit_pkg::AddrW-1:0]    addr;
  logic [rbit_pkg::MbW-1:0]      region_mb;

  modport source (output valid, cmd, addr, region_mb, input ready);
  modport sink   (input valid, cmd, addr, region_mb, output ready);
endinterface

interface rbit_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [rbit_pkg::StatusW-1:0]  status;
  logic [rbit_pkg::BufIdxW-1:0]  buf_index;
  logic [rbit_pkg::BlocksW-1:0]  blk_count;

  modport source (output valid, status, buf_index, blk_count, input ready);
  modport sink   (input valid, status, buf_index, blk_count, output ready);
endinterface

`default_nettype wire

// ===== design/rbit_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on rbit_pkg for the dividend and divisor widths.
`default_nettype none

module rbit_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [rbit_pkg::DivW-1:0]   dividend_i,
  input  wire logic [rbit_pkg::PagesW-1:0] divisor_i,
  output logic                             done_o,
  output logic [rbit_pkg::DivW-1:0]        quot_o
);

  localparam int unsigned CntW = $clog2(rbit_pkg::DivW + 1);

  logic [CntW-1:0]                 cnt_q, cnt_d;
  logic [rbit_pkg::DivW-1:0]       dvd_q, dvd_d;
  logic [rbit_pkg::PagesW-1:0]     rem_q, rem_d;
  logic [rbit_pkg::PagesW-1:0]     dsr_q, dsr_d;
  logic [rbit_pkg::PagesW:0]       trial;
  logic                            qbit;

  // One shift-and-subtract step; the dividend register fills with quotient bits.
  assign trial = {rem_q, dvd_q[rbit_pkg::DivW-1]};
  assign qbit  = (trial >= {1'b0, dsr_q});

  always_comb begin
    cnt_d = cnt_q;
    dvd_d = dvd_q;
    rem_d = rem_q;
    dsr_d = dsr_q;
    if (start_i) begin
      cnt_d = CntW'(rbit_pkg::DivW);
      dvd_d = dividend_i;
      rem_d = '0;
      dsr_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      dvd_d = {dvd_q[rbit_pkg::DivW-2:0], qbit};
      rem_d = qbit ? rbit_pkg::PagesW'(trial - {1'b0, dsr_q})
                   : trial[rbit_pkg::PagesW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = (cnt_q == '0);
  assign quot_o = dvd_q;

endmodule

`default_nettype wire

// ===== design/rbit_dp.sv =====
// Datapath: configuration registers, region table memories, scan compare,
// block multiply, divider and result registers.
// Depends on rbit_pkg and rbit_div.
`default_nettype none

module rbit_dp #(
  parameter int unsigned MAX_REGION_SLOTS = rbit_pkg::MaxRegionSlots
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [rbit_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [rbit_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire logic [rbit_pkg::CmdW-1:0]      in_cmd_i,
  input  wire logic [rbit_pkg::AddrW-1:0]     in_addr_i,
  input  wire logic [rbit_pkg::MbW-1:0]       in_region_mb_i,
  input  wire rbit_pkg::cmd_t                 cmd_i,
  output rbit_pkg::sts_t                      sts_o,
  output logic [rbit_pkg::StatusW-1:0]        out_status_o,
  output logic [rbit_pkg::BufIdxW-1:0]        out_buf_index_o,
  output logic [rbit_pkg::BlocksW-1:0]        out_blk_count_o
);

  localparam int unsigned IdxW = (MAX_REGION_SLOTS > 1) ? $clog2(MAX_REGION_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_REGION_SLOTS + 1);

  // Configuration
  logic [rbit_pkg::PagesW-1:0]      block_pages_q;
  logic [rbit_pkg::MaxRegionsW-1:0] max_regions_q;

  // Latched request word
  logic [rbit_pkg::CmdW-1:0]        cmd_q;
  logic [rbit_pkg::AddrW-1:0]       addr_q;
  logic [rbit_pkg::MbW-1:0]         mb_q;

  // Table bookkeeping
  logic [CntW-1:0]                  used_q;
  logic [CntW-1:0]                  scan_q;
  logic [rbit_pkg::BufIdxW-1:0]     next_base_q;

  // Region table memories
  logic [rbit_pkg::AddrW-1:0]       base_mem  [MAX_REGION_SLOTS];
  logic [rbit_pkg::LimitW-1:0]      limit_mem [MAX_REGION_SLOTS];
  logic [rbit_pkg::PagesW-1:0]      pages_mem [MAX_REGION_SLOTS];
  logic [rbit_pkg::BufIdxW-1:0]     ibase_mem [MAX_REGION_SLOTS];

  // Registered read data
  logic [rbit_pkg::AddrW-1:0]       rd_base_q;
  logic [rbit_pkg::LimitW-1:0]      rd_limit_q;
  logic [rbit_pkg::PagesW-1:0]      rd_pages_q;
  logic [rbit_pkg::BufIdxW-1:0]     rd_ibase_q;

  // Add arithmetic
  logic [rbit_pkg::BlocksW-1:0]     blocks_q;
  logic [rbit_pkg::ProdW-1:0]       prod_q;
  logic [rbit_pkg::LimitW-1:0]      new_limit;

  // Divider
  logic [rbit_pkg::DivW-1:0]        div_dividend;
  logic [rbit_pkg::PagesW-1:0]      div_divisor;
  logic [rbit_pkg::DivW-1:0]        quot;
  logic                             div_done;

  // Lookup compare
  logic [rbit_pkg::AddrW-1:0]       diff;
  logic                             hit;

  // Result staging and output word
  logic [rbit_pkg::StatusW-1:0]     pend_status_q;
  logic [rbit_pkg::BufIdxW-1:0]     pend_idx_q;
  logic [rbit_pkg::BlocksW-1:0]     pend_cnt_q;
  logic [rbit_pkg::StatusW-1:0]     out_status_q;
  logic [rbit_pkg::BufIdxW-1:0]     out_idx_q;
  logic [rbit_pkg::BlocksW-1:0]     out_cnt_q;

  // Table limit is the smaller of the register and the table depth.
  logic [7:0] lim8;
  assign lim8 = (8'(max_regions_q) > 8'(MAX_REGION_SLOTS)) ? 8'(MAX_REGION_SLOTS)
                                                           : 8'(max_regions_q);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_pages_q <= rbit_pkg::PagesW'(rbit_pkg::BlockPagesReset);
      max_regions_q <= rbit_pkg::MaxRegionsW'(rbit_pkg::MaxRegionsReset);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rbit_pkg::CFG_BLOCK_PAGES: block_pages_q <= cfg_wdata_i;
        rbit_pkg::CFG_MAX_REGIONS: max_regions_q <= cfg_wdata_i[rbit_pkg::MaxRegionsW-1:0];
        default: ;
      endcase
    end
  end

  // Request word capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cmd_q  <= in_cmd_i;
      addr_q <= in_addr_i;
      mb_q   <= in_region_mb_i;
    end
  end

  // Region count, running index base and scan pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      next_base_q <= '0;
      scan_q      <= '0;
    end else begin
      if (cmd_i.write_entry) begin
        used_q      <= CntW'(used_q + 1'b1);
        next_base_q <= next_base_q + rbit_pkg::BufIdxW'(blocks_q);
      end
      if (cmd_i.scan_clr) begin
        scan_q <= '0;
      end else if (cmd_i.scan_rd) begin
        scan_q <= CntW'(scan_q + 1'b1);
      end
    end
  end

  // Region end address, computed without wrap.
  assign new_limit = {1'b0, addr_q}
                   + rbit_pkg::LimitW'({prod_q, {rbit_pkg::PageShift{1'b0}}});

  // Table write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_entry) begin
      base_mem[used_q[IdxW-1:0]]  <= addr_q;
      limit_mem[used_q[IdxW-1:0]] <= new_limit;
      pages_mem[used_q[IdxW-1:0]] <= block_pages_q;
      ibase_mem[used_q[IdxW-1:0]] <= next_base_q;
    end
  end

  // Table read port, registered
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd) begin
      rd_base_q  <= base_mem[scan_q[IdxW-1:0]];
      rd_limit_q <= limit_mem[scan_q[IdxW-1:0]];
      rd_pages_q <= pages_mem[scan_q[IdxW-1:0]];
      rd_ibase_q <= ibase_mem[scan_q[IdxW-1:0]];
    end
  end

  // Region hit test and page offset within the region
  assign diff = addr_q - rd_base_q;
  assign hit  = (addr_q >= rd_base_q) && ({1'b0, addr_q} < rd_limit_q);

  // Divider operands: size in pages over block pages for an add,
  // page offset over the region's block pages for a lookup.
  always_comb begin
    if (cmd_q == rbit_pkg::CMD_LOOKUP) begin
      div_dividend = diff[rbit_pkg::PageShift +: rbit_pkg::DivW];
      div_divisor  = rd_pages_q;
    end else begin
      div_dividend = rbit_pkg::DivW'({mb_q, {rbit_pkg::MibShift{1'b0}}});
      div_divisor  = block_pages_q;
    end
  end

  rbit_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Block count and region size in pages
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      blocks_q <= quot[rbit_pkg::BlocksW-1:0];
      prod_q   <= rbit_pkg::ProdW'(quot[rbit_pkg::BlocksW-1:0])
                * rbit_pkg::ProdW'(block_pages_q);
    end
  end

  // Result staging
  always_ff @(posedge clk_i) begin
    case (cmd_i.res)
      rbit_pkg::RES_FULL: begin
        pend_status_q <= rbit_pkg::ST_FULL;
        pend_idx_q    <= '0;
        pend_cnt_q    <= '0;
      end
      rbit_pkg::RES_SMALL: begin
        pend_status_q <= rbit_pkg::ST_SMALL;
        pend_idx_q    <= '0;
        pend_cnt_q    <= '0;
      end
      rbit_pkg::RES_MISS: begin
        pend_status_q <= rbit_pkg::ST_MISS;
        pend_idx_q    <= '0;
        pend_cnt_q    <= '0;
      end
      rbit_pkg::RES_ADD_OK: begin
        pend_status_q <= rbit_pkg::ST_OK;
        pend_idx_q    <= next_base_q;
        pend_cnt_q    <= blocks_q;
      end
      rbit_pkg::RES_LK_OK: begin
        pend_status_q <= rbit_pkg::ST_OK;
        pend_idx_q    <= rd_ibase_q + quot[rbit_pkg::BufIdxW-1:0];
        pend_cnt_q    <= '0;
      end
      default: ;
    endcase
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= pend_status_q;
      out_idx_q    <= pend_idx_q;
      out_cnt_q    <= pend_cnt_q;
    end
  end

  assign out_status_o    = out_status_q;
  assign out_buf_index_o = out_idx_q;
  assign out_blk_count_o = out_cnt_q;

  // Status to the controller
  assign sts_o.is_lookup  = (cmd_q == rbit_pkg::CMD_LOOKUP);
  assign sts_o.addr_zero  = (addr_q == '0);
  assign sts_o.full       = (8'(used_q) >= lim8);
  assign sts_o.pages_zero = (block_pages_q == '0);
  assign sts_o.div_done   = div_done;
  assign sts_o.quot_zero  = (quot == '0);
  assign sts_o.scan_end   = (scan_q == used_q);
  assign sts_o.hit        = hit;

  // A region is only written into a table that has room.
  a_write_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write_entry |-> !sts_o.full)
    else $error("region written into a full table");

  // Each write adds one region and advances the index base by its blocks.
  a_write_bookkeeping: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write_entry |=> (used_q == CntW'($past(used_q) + 1'b1)) &&
      (next_base_q == $past(next_base_q) + rbit_pkg::BufIdxW'($past(blocks_q))))
    else $error("region count or index base out of step");

  // The scan never reads past the filled part of the table.
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_rd |-> (scan_q < used_q))
    else $error("scan read beyond the filled regions");

endmodule

`default_nettype wire

// ===== design/rbit_ctrl.sv =====
// Controller state machine: sequences add and lookup commands over the
// datapath and owns the channel handshakes. Depends on rbit_pkg.
`default_nettype none

module rbit_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output rbit_pkg::cmd_t      cmd_o,
  input  wire rbit_pkg::sts_t sts_i
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_DECODE  = 8'b0000_0010,
    S_ADD_DIV = 8'b0000_0100,
    S_ADD_WR  = 8'b0000_1000,
    S_LK_RD   = 8'b0001_0000,
    S_LK_CHK  = 8'b0010_0000,
    S_LK_DIV  = 8'b0100_0000,
    S_RESP    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Next state and datapath commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.res  = rbit_pkg::RES_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.is_lookup) begin
          if (sts_i.addr_zero) begin
            cmd_o.res = rbit_pkg::RES_MISS;
            state_d   = S_RESP;
          end else begin
            cmd_o.scan_clr = 1'b1;
            state_d        = S_LK_RD;
          end
        end else if (sts_i.full) begin
          cmd_o.res = rbit_pkg::RES_FULL;
          state_d   = S_RESP;
        end else if (sts_i.pages_zero) begin
          cmd_o.res = rbit_pkg::RES_SMALL;
          state_d   = S_RESP;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_ADD_DIV;
        end
      end
      S_ADD_DIV: begin
        if (sts_i.div_done) begin
          if (sts_i.quot_zero) begin
            cmd_o.res = rbit_pkg::RES_SMALL;
            state_d   = S_RESP;
          end else begin
            cmd_o.mul = 1'b1;
            state_d   = S_ADD_WR;
          end
        end
      end
      S_ADD_WR: begin
        cmd_o.write_entry = 1'b1;
        cmd_o.res         = rbit_pkg::RES_ADD_OK;
        state_d           = S_RESP;
      end
      S_LK_RD: begin
        if (sts_i.scan_end) begin
          cmd_o.res = rbit_pkg::RES_MISS;
          state_d   = S_RESP;
        end else begin
          cmd_o.scan_rd = 1'b1;
          state_d       = S_LK_CHK;
        end
      end
      S_LK_CHK: begin
        if (sts_i.hit) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_LK_DIV;
        end else begin
          state_d = S_LK_RD;
        end
      end
      S_LK_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.res = rbit_pkg::RES_LK_OK;
          state_d   = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output word valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // One word at a time: after an accept the input stays closed.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second word accepted while one is in flight");

  // The output register is only overwritten once its word has left.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("output word overwritten before it was taken");

  // The divider starts only from decode or a region hit.
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> ((state_q == S_DECODE) || (state_q == S_LK_CHK && sts_i.hit)))
    else $error("divider started from an unexpected state");

endmodule

`default_nettype wire

// ===== design/region_buffer_index_table.sv =====
// Top level of the region buffer index table.
// Depends on rbit_pkg, rbit_chan_if, rbit_ctrl and rbit_dp.
//
// Usage:
// Request words arrive on req_i (valid/ready). cmd selects an add (region base
// in addr, size in MiB in region_mb) or a lookup of the byte address in addr.
// Every request word produces exactly one response word on rsp_o: status,
// buffer index and, for an add, the region's block count.
// Configuration (block_pages, max_regions) is written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i while no request is in flight.
// One word is worked on at a time. A stored add runs the 35-step serial
// divider that splits the size into blocks, then writes the region; an add
// that holds no whole block is answered without being stored. A lookup reads
// and compares the regions one after another and answers a miss once all are
// scanned; on a hit it runs the divider on the page offset. A lookup of
// address zero and an add refused for a full table or a zero block size
// answer straight from decode. The next word is taken the cycle after a
// response is placed in the output register.
// A stalled receiver holds the response in the output register; the block
// finishes the next word and then waits for that register to empty.
// Reset empties the table and restores block_pages to 2 and max_regions to 8.
`default_nettype none

module region_buffer_index_table #(
  parameter int unsigned MAX_REGION_SLOTS = rbit_pkg::MaxRegionSlots
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  rbit_req_if.sink                           req_i,
  rbit_rsp_if.source                         rsp_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [rbit_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [rbit_pkg::CfgDataW-1:0] cfg_wdata_i
);

  rbit_pkg::cmd_t cmd;
  rbit_pkg::sts_t sts;
  logic           in_ready;
  logic           out_valid;

  rbit_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  rbit_dp #(
    .MAX_REGION_SLOTS (MAX_REGION_SLOTS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_cmd_i        (req_i.cmd),
    .in_addr_i       (req_i.addr),
    .in_region_mb_i  (req_i.region_mb),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_status_o    (rsp_o.status),
    .out_buf_index_o (rsp_o.buf_index),
    .out_blk_count_o (rsp_o.blk_count)
  );

  assign req_i.ready = in_ready;
  assign rsp_o.valid = out_valid;

endmodule

`default_nettype wire
